### hw/rtl/i2cbt_pkg.sv
// Shared types and constants for the I2C bit-level target decoder.
package i2cbt_pkg;

   // Bus phase codes held in the phase register.
   localparam logic [4:0] PH_STOPPED = 5'd0;
   localparam logic [4:0] PH_TAKE_B7 = 5'd1;
   localparam logic [4:0] PH_TAKE_B0 = 5'd8;
   localparam logic [4:0] PH_ACK_OUT = 5'd9;
   localparam logic [4:0] PH_GIVE_B7 = 5'd10;
   localparam logic [4:0] PH_GIVE_B0 = 5'd17;
   localparam logic [4:0] PH_ACK_IN  = 5'd18;
   localparam logic [4:0] PH_NACKED  = 5'd19;

   // Line select codes of the input word.
   localparam logic LINE_SDA = 1'b0;
   localparam logic LINE_SCL = 1'b1;

   // Bus event codes reported with every result word.
   typedef enum logic [2:0] {
      EV_NONE  = 3'd0,
      EV_START = 3'd1,
      EV_WRITE = 3'd2,
      EV_READ  = 3'd3,
      EV_NACK  = 3'd4,
      EV_END   = 3'd5
   } event_type;

   // One line change from the controller.
   typedef struct packed {
      logic       func;
      logic       level;
      logic [7:0] rx_byte;
   } req_word_type;

   // One result word.
   typedef struct packed {
      logic       sda_level;
      logic [2:0] event_res;
      logic [7:0] event_byte;
   } rsp_word_type;

endpackage

### hw/rtl/i2cbt_if.sv
// Valid/ready channel interfaces for the request and response words.
interface i2cbt_req_if;
   logic       valid;
   logic       ready;
   logic       func;
   logic       level;
   logic [7:0] rx_byte;

   modport source (output valid, output func, output level, output rx_byte, input ready);
   modport sink   (input valid, input func, input level, input rx_byte, output ready);
endinterface

interface i2cbt_rsp_if;
   logic       valid;
   logic       ready;
   logic       sda_level;
   logic [2:0] event_res;
   logic [7:0] event_byte;

   modport source (output valid, output sda_level, output event_res, output event_byte,
                   input ready);
   modport sink   (input valid, input sda_level, input event_res, input event_byte,
                   output ready);
endinterface

### hw/rtl/i2c_bitbang_target_decoder_unit.sv
// Top level of the I2C bit-level target decoder.
//
// Usage:
//  - req_chan carries one line change per word: func selects SDA (0) or
//    SCL (1), level is the new controller level, and rx_byte is the byte
//    the attached device offers when a read byte begins.
//  - rsp_chan returns exactly one word per request: the wired-AND SDA
//    level, a bus event code and the byte that goes with that event.
//  - A word accepted at a clock edge is held in the input register, is
//    processed by the next-state logic from there, and lands in the
//    result register once that register has room; rsp_chan.valid then
//    rises and the result can be taken.
//  - Throughput is one word per cycle unless rsp_chan stalls; the input
//    and result registers each hold one word, so a request is taken while a
//    result waits as long as the result register drains or the input stage is free.
//  - When rsp_chan.ready stays low, the result register holds its word, the
//    input register fills, and req_chan.ready then drops until space frees.
//  - Synchronous reset empties both registers and returns the bus state to
//    stopped with both lines high and SDA released.
module i2c_bitbang_target_decoder_unit
   import i2cbt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   i2cbt_req_if.sink   req_chan,
   i2cbt_rsp_if.source rsp_chan
);

   logic         in_valid;
   req_word_type in_word;
   rsp_word_type core_result;
   logic         out_space;
   logic         advance;

   // A word moves from the input register when the result register has room.
   assign advance = in_valid && out_space;

   i2cbt_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .advance    (advance),
      .word_valid (in_valid),
      .word       (in_word)
   );

   i2cbt_core u_core (
      .clock   (clock),
      .reset   (reset),
      .fire    (advance),
      .in_word (in_word),
      .result  (core_result)
   );

   i2cbt_out_stage u_out_stage (
      .clock    (clock),
      .reset    (reset),
      .load     (advance),
      .word     (core_result),
      .space    (out_space),
      .rsp_chan (rsp_chan)
   );

   // Only START and write events carry a byte.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !(rsp_chan.event_res == EV_START ||
                           rsp_chan.event_res == EV_WRITE))
      |-> (rsp_chan.event_byte == 8'd0))
      else $error("event byte set on an event without data");

   // An address or write byte is always acknowledged by pulling SDA low.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && (rsp_chan.event_res == EV_START ||
                          rsp_chan.event_res == EV_WRITE))
      |-> !rsp_chan.sda_level)
      else $error("byte event without device acknowledge");

   // A NACK is only seen with SDA released and high.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.event_res == EV_NACK) |-> rsp_chan.sda_level)
      else $error("NACK reported with SDA low");

   // Both stages come out of reset empty.
   assert property (@(posedge clock)
      reset |=> (req_chan.ready && !rsp_chan.valid))
      else $error("stages not empty after reset");

endmodule

### hw/rtl/i2cbt_in_stage.sv
// Input register stage that captures one line-change word per cycle while req_chan.ready is high.
module i2cbt_in_stage
   import i2cbt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   i2cbt_req_if.sink    req_chan,
   input  logic         advance,
   output logic         word_valid,
   output req_word_type word
);

   logic         valid_ff;
   logic         valid_in;
   req_word_type word_ff;
   logic         take;

   // A new word enters when the stage is empty or its word moves on now.
   assign req_chan.ready = !valid_ff || advance;
   assign take           = req_chan.valid && req_chan.ready;
   assign valid_in       = take ? 1'b1 : (advance ? 1'b0 : valid_ff);

   // Control register with synchronous reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload register, loaded on each accepted word.
   always_ff @(posedge clock) begin
      if (take) begin
         word_ff.func    <= req_chan.func;
         word_ff.level   <= req_chan.level;
         word_ff.rx_byte <= req_chan.rx_byte;
      end
   end

   assign word_valid = valid_ff;
   assign word       = word_ff;

endmodule

### hw/rtl/i2cbt_core.sv
// Bus state tracking and next-state decode for one line change per cycle while fire is set.
module i2cbt_core
   import i2cbt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         fire,
   input  req_word_type in_word,
   output rsp_word_type result
);

   logic [4:0] phase_ff, phase_in;
   logic       prev_sda_ff, prev_sda_in;
   logic       prev_scl_ff, prev_scl_in;
   logic       drive_ff, drive_in;
   logic [7:0] shift_ff, shift_in;
   logic       addr_valid_ff, addr_valid_in;
   logic [7:0] addr_byte_ff, addr_byte_in;
   event_type  event_code;
   logic [7:0] event_byte;
   logic [7:0] give_src;
   logic       read_sel;

   // Next-state decode for the word in the input register.
   always_comb begin
      phase_in      = phase_ff;
      prev_sda_in   = prev_sda_ff;
      prev_scl_in   = prev_scl_ff;
      drive_in      = drive_ff;
      shift_in      = shift_ff;
      addr_valid_in = addr_valid_ff;
      addr_byte_in  = addr_byte_ff;
      event_code    = EV_NONE;
      event_byte    = 8'd0;
      give_src      = (phase_ff == PH_GIVE_B7) ? in_word.rx_byte : shift_ff;
      read_sel      = addr_byte_ff[0];

      if (in_word.func == LINE_SDA) begin
         // Data line change: START or STOP when the clock line is high.
         if (in_word.level != prev_sda_ff) begin
            prev_sda_in = in_word.level;
            if (prev_scl_ff) begin
               drive_in      = 1'b1;
               addr_valid_in = 1'b0;
               if (!in_word.level) begin
                  phase_in = PH_TAKE_B7;
               end else begin
                  phase_in   = PH_STOPPED;
                  event_code = addr_valid_ff ? EV_END : EV_NONE;
               end
            end
         end
      end else if (in_word.level != prev_scl_ff) begin
         // Clock line change: falling edge releases, rising edge steps the phase.
         prev_scl_in = in_word.level;
         drive_in    = 1'b1;
         if (in_word.level) begin
            unique case (phase_ff) inside
               [PH_TAKE_B7:PH_TAKE_B0]: begin
                  shift_in = {shift_ff[6:0], prev_sda_ff};
                  phase_in = phase_ff + 5'd1;
               end
               PH_ACK_OUT: begin
                  drive_in   = 1'b0;
                  event_byte = shift_ff;
                  if (!addr_valid_ff) begin
                     addr_valid_in = 1'b1;
                     addr_byte_in  = shift_ff;
                     event_code    = EV_START;
                     read_sel      = shift_ff[0];
                  end else begin
                     event_code = EV_WRITE;
                  end
                  phase_in = read_sel ? PH_GIVE_B7 : PH_TAKE_B7;
               end
               [PH_GIVE_B7:PH_GIVE_B0]: begin
                  if (phase_ff == PH_GIVE_B7) begin
                     event_code = EV_READ;
                  end
                  drive_in = give_src[7];
                  shift_in = {give_src[6:0], 1'b0};
                  phase_in = phase_ff + 5'd1;
               end
               PH_ACK_IN: begin
                  if (prev_sda_ff) begin
                     phase_in   = PH_NACKED;
                     event_code = EV_NACK;
                  end else begin
                     phase_in = PH_GIVE_B7;
                  end
               end
               default: begin
                  // Stopped, after a NACK, or an unused code: nothing to do.
                  phase_in = phase_ff;
               end
            endcase
         end
      end

      result.sda_level  = drive_in & prev_sda_in;
      result.event_res  = event_code;
      result.event_byte = event_byte;
   end

   // Bus state registers, updated once per processed word.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_STOPPED;
         prev_sda_ff   <= 1'b1;
         prev_scl_ff   <= 1'b1;
         drive_ff      <= 1'b1;
         shift_ff      <= 8'd0;
         addr_valid_ff <= 1'b0;
         addr_byte_ff  <= 8'd0;
      end else if (fire) begin
         phase_ff      <= phase_in;
         prev_sda_ff   <= prev_sda_in;
         prev_scl_ff   <= prev_scl_in;
         drive_ff      <= drive_in;
         shift_ff      <= shift_in;
         addr_valid_ff <= addr_valid_in;
         addr_byte_ff  <= addr_byte_in;
      end
   end

endmodule

### hw/rtl/i2cbt_out_stage.sv
// Result register that holds one word until the receiver takes it.
module i2cbt_out_stage
   import i2cbt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         load,
   input  rsp_word_type word,
   output logic         space,
   i2cbt_rsp_if.source  rsp_chan
);

   logic         valid_ff;
   logic         valid_in;
   rsp_word_type word_ff;

   // The register is free when empty or when its word is taken this cycle.
   assign space    = !valid_ff || rsp_chan.ready;
   assign valid_in = load ? 1'b1 : (rsp_chan.ready ? 1'b0 : valid_ff);

   // Control register with synchronous reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload register.
   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= word;
      end
   end

   assign rsp_chan.valid      = valid_ff;
   assign rsp_chan.sda_level  = word_ff.sda_level;
   assign rsp_chan.event_res  = word_ff.event_res;
   assign rsp_chan.event_byte = word_ff.event_byte;

endmodule

### tb/i2c_bitbang_target_decoder_unit_tb.sv
// Self-checking testbench for the I2C bit-level target decoder, driven by SDA and SCL changes.
`timescale 1ns / 1ps

module i2c_bitbang_target_decoder_unit_tb;
   import i2cbt_pkg::*;

   localparam int QUIET_LIMIT = 1000;
   localparam int PRINT_LIMIT = 30;

   logic clock = 1'b0;
   logic reset = 1'b1;

   i2cbt_req_if req_chan();
   i2cbt_rsp_if rsp_chan();

   i2c_bitbang_target_decoder_unit u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Free-running clock with an 8 ns period.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Mirror of the target's bus state, advanced once per accepted word.
   logic [4:0] bus_phase = PH_STOPPED;
   logic       seen_sda = 1'b1;
   logic       seen_scl = 1'b1;
   logic       tgt_drive = 1'b1;
   logic [7:0] shreg = 8'h00;
   logic       addr_seen = 1'b0;
   logic [7:0] addr_latched = 8'h00;

   // Line levels that the stimulus side has driven so far.
   logic drv_sda = 1'b1;
   logic drv_scl = 1'b1;

   rsp_word_type bus_results_due[$];
   int           words_sent = 0;
   int           results_checked = 0;
   int           mismatch_count = 0;
   int           event_seen[6] = '{default: 0};
   bit           idle_on = 1'b1;

   // Works out the result word for one line change and advances the bus state.
   function automatic rsp_word_type decode_line_change(input req_word_type w);
      rsp_word_type r;
      event_type    ev;
      logic [7:0]   ev_byte;
      logic         drive;
      ev = EV_NONE;
      ev_byte = 8'h00;
      drive = tgt_drive;
      if (w.func == LINE_SDA) begin
         if (w.level != seen_sda) begin
            seen_sda = w.level;
            // A data change while SCL is high is a START or a STOP.
            if (seen_scl) begin
               drive = 1'b1;
               if (!w.level) begin
                  bus_phase = PH_TAKE_B7;
                  addr_seen = 1'b0;
               end else begin
                  if (addr_seen) ev = EV_END;
                  addr_seen = 1'b0;
                  bus_phase = PH_STOPPED;
               end
            end
         end
      end else if (w.level != seen_scl) begin
         seen_scl = w.level;
         drive = 1'b1;
         if (w.level) begin
            if (bus_phase >= PH_TAKE_B7 && bus_phase <= PH_TAKE_B0) begin
               shreg = {shreg[6:0], seen_sda};
               bus_phase = bus_phase + 5'd1;
            end else if (bus_phase == PH_ACK_OUT) begin
               // The target pulls SDA low to acknowledge the byte it took.
               drive = 1'b0;
               if (!addr_seen) begin
                  addr_seen = 1'b1;
                  addr_latched = shreg;
                  ev = EV_START;
               end else begin
                  ev = EV_WRITE;
               end
               ev_byte = shreg;
               bus_phase = addr_latched[0] ? PH_GIVE_B7 : PH_TAKE_B7;
            end else if (bus_phase >= PH_GIVE_B7 && bus_phase <= PH_GIVE_B0) begin
               if (bus_phase == PH_GIVE_B7) begin
                  shreg = w.rx_byte;
                  ev = EV_READ;
               end
               drive = shreg[7];
               shreg = {shreg[6:0], 1'b0};
               bus_phase = bus_phase + 5'd1;
            end else if (bus_phase == PH_ACK_IN) begin
               if (seen_sda) begin
                  bus_phase = PH_NACKED;
                  ev = EV_NACK;
               end else begin
                  bus_phase = PH_GIVE_B7;
               end
            end
         end
      end
      tgt_drive = drive;
      r.sda_level = tgt_drive & seen_sda;
      r.event_res = ev;
      r.event_byte = ev_byte;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT)
         $display("mismatch at result %0d: %s got %0d, expected %0d",
                  results_checked, what, got, want);
   endtask

   // Sends one word, with an occasional idle burst before it.
   task automatic drive_line_change(input logic f, input logic l, input logic [7:0] rx);
      req_word_type w;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.func <= f;
      req_chan.level <= l;
      req_chan.rx_byte <= rx;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      w.func = f;
      w.level = l;
      w.rx_byte = rx;
      bus_results_due.push_back(decode_line_change(w));
      words_sent++;
      if (f == LINE_SDA) drv_sda = l;
      else drv_scl = l;
   endtask

   task automatic set_line(input logic f, input logic l);
      drive_line_change(f, l, 8'($urandom_range(0, 255)));
   endtask

   task automatic scl_low();
      if (drv_scl) set_line(LINE_SCL, 1'b0);
   endtask

   // One clock pulse with SDA set up while SCL is low; SCL is left high.
   task automatic clock_bit(input logic b);
      scl_low();
      if (drv_sda != b) set_line(LINE_SDA, b);
      set_line(LINE_SCL, 1'b1);
   endtask

   task automatic clock_byte(input logic [7:0] b);
      for (int i = 7; i >= 0; i--) clock_bit(b[i]);
   endtask

   task automatic bus_start();
      if (!drv_sda) begin
         scl_low();
         set_line(LINE_SDA, 1'b1);
      end
      if (!drv_scl) set_line(LINE_SCL, 1'b1);
      set_line(LINE_SDA, 1'b0);
   endtask

   task automatic bus_stop();
      if (drv_sda) begin
         scl_low();
         set_line(LINE_SDA, 1'b0);
      end
      if (!drv_scl) set_line(LINE_SCL, 1'b1);
      set_line(LINE_SDA, 1'b1);
   endtask

   // Address byte, then nbytes of write data or read data; reads usually end on a NACK.
   task automatic run_transfer(input logic rd, input int nbytes, input bit end_with_stop);
      logic [7:0] addr;
      addr = {7'($urandom_range(0, 127)), rd};
      bus_start();
      clock_byte(addr);
      clock_bit(1'b1);
      for (int k = 0; k < nbytes; k++) begin
         if (rd) begin
            clock_byte(8'hFF);
            clock_bit((k == nbytes - 1) && ($urandom_range(0, 3) != 0));
         end else begin
            clock_byte(8'($urandom_range(0, 255)));
            clock_bit(1'b1);
         end
      end
      if (end_with_stop) bus_stop();
   endtask

   // Single line cases: unchanged levels, idle clocks, bare START and STOP, SDA under low SCL.
   task automatic test_line_cases();
      drive_line_change(LINE_SDA, 1'b1, 8'hFF);
      drive_line_change(LINE_SCL, 1'b1, 8'h00);
      drive_line_change(LINE_SCL, 1'b0, 8'hFF);
      drive_line_change(LINE_SCL, 1'b1, 8'h00);
      drive_line_change(LINE_SDA, 1'b0, 8'hA5);
      drive_line_change(LINE_SDA, 1'b1, 8'h5A);
      drive_line_change(LINE_SCL, 1'b0, 8'h00);
      drive_line_change(LINE_SDA, 1'b0, 8'hFF);
      drive_line_change(LINE_SDA, 1'b1, 8'h00);
      drive_line_change(LINE_SCL, 1'b0, 8'hFF);
      drive_line_change(LINE_SCL, 1'b1, 8'h00);
   endtask

   task automatic test_write_transfers(input int target);
      while (words_sent < target) run_transfer(1'b0, $urandom_range(0, 3), 1'b1);
   endtask

   // Reads, sometimes with extra clocks after the NACK before the STOP.
   task automatic test_read_transfers(input int target);
      while (words_sent < target) begin
         run_transfer(1'b1, $urandom_range(1, 3), 1'b0);
         if ($urandom_range(0, 1)) clock_bit(1'b1);
         bus_stop();
      end
   endtask

   // Chains of transfers joined by repeated STARTs, closed by one STOP.
   task automatic test_repeated_starts(input int target);
      while (words_sent < target) begin
         repeat ($urandom_range(2, 3))
            run_transfer(1'($urandom_range(0, 1)), $urandom_range(0, 2), 1'b0);
         bus_stop();
      end
   endtask

   // Random line noise, transfers cut short and a share of clean transfers.
   task automatic test_broken_sequences(input int target);
      while (words_sent < target) begin
         case ($urandom_range(0, 3))
            0: repeat ($urandom_range(1, 8))
                  drive_line_change(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                    8'($urandom_range(0, 255)));
            1: begin
               bus_start();
               repeat ($urandom_range(1, 12)) clock_bit(1'($urandom_range(0, 1)));
               bus_stop();
            end
            2: begin
               run_transfer(1'($urandom_range(0, 1)), 1, 1'b0);
               repeat ($urandom_range(1, 10)) clock_bit(1'($urandom_range(0, 1)));
               if ($urandom_range(0, 1)) bus_start();
               else bus_stop();
            end
            default: run_transfer(1'($urandom_range(0, 1)), $urandom_range(0, 2), 1'b1);
         endcase
      end
   endtask

   // Transfers at full rate on both sides.
   task automatic test_back_to_back(input int target);
      idle_on = 1'b0;
      while (words_sent < target)
         run_transfer(1'($urandom_range(0, 1)), $urandom_range(0, 2), 1'b1);
   endtask

   // Response side: random stall bursts while idling is allowed.
   initial begin
      int hold_cnt;
      hold_cnt = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_cnt > 0) hold_cnt--;
         else if (idle_on && $urandom_range(0, 4) == 0) hold_cnt = $urandom_range(1, 6);
         rsp_chan.ready <= (hold_cnt == 0);
      end
   end

   // Compares each result word with the oldest expected one.
   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (bus_results_due.size() == 0) begin
            report_mismatch("unexpected word, event", rsp_chan.event_res, EV_NONE);
         end else begin
            want = bus_results_due.pop_front();
            if (rsp_chan.sda_level !== want.sda_level)
               report_mismatch("sda_level", rsp_chan.sda_level, want.sda_level);
            if (rsp_chan.event_res !== want.event_res)
               report_mismatch("event_res", rsp_chan.event_res, want.event_res);
            if (rsp_chan.event_byte !== want.event_byte)
               report_mismatch("event_byte", rsp_chan.event_byte, want.event_byte);
            if (want.event_res <= EV_END) event_seen[want.event_res]++;
         end
         results_checked++;
      end
   end

   // Ends the run when neither channel moves a word for too long.
   initial begin
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            quiet = 0;
         else
            quiet++;
         if (quiet >= QUIET_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles", QUIET_LIMIT);
            $display("status: fail");
            $finish;
         end
      end
   end

   initial begin
      req_chan.valid = 1'b0;
      req_chan.func = LINE_SDA;
      req_chan.level = 1'b1;
      req_chan.rx_byte = 8'h00;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_line_cases();
      test_write_transfers(150);
      test_read_transfers(300);
      test_repeated_starts(380);
      test_broken_sequences(500);
      test_back_to_back(620);
      req_chan.valid <= 1'b0;

      // Drain the pipeline, then keep watching for stray words.
      while (bus_results_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("sent %0d line changes, checked %0d result words", words_sent, results_checked);
      $display("bus events: start %0d, write %0d, read %0d, nack %0d, end %0d",
               event_seen[EV_START], event_seen[EV_WRITE], event_seen[EV_READ],
               event_seen[EV_NACK], event_seen[EV_END]);
      if (mismatch_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

### sim.f
hw/rtl/i2cbt_pkg.sv
hw/rtl/i2cbt_if.sv
hw/rtl/i2cbt_in_stage.sv
hw/rtl/i2cbt_core.sv
hw/rtl/i2cbt_out_stage.sv
hw/rtl/i2c_bitbang_target_decoder_unit.sv
tb/i2c_bitbang_target_decoder_unit_tb.sv
